// ----- src/apca_pkg.sv -----
// Shared definitions for the ARGB pixel channel ALU: operation codes,
// channel layout constants, the lane control struct and the divide-by-255 helper.
// No dependencies.
package apca_pkg;

    localparam int CHAN_W    = 8;
    localparam int NUM_LANES = 4;
    localparam int PIX_W     = CHAN_W * NUM_LANES;
    localparam int PROD_W    = 2 * CHAN_W;
    localparam int FUNC_W    = 3;
    localparam int ALPHA_LANE = 3;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

    localparam logic [FUNC_W-1:0] FUNC_ADD   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SUB   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_MIN   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_MAX   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_MOD   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_BLEND = 3'd5;

    // Pipeline control that the top level hands to every lane.
    typedef struct packed {
        logic load_s1;
    } lane_ctl_t;

    typedef logic [NUM_LANES-1:0][CHAN_W-1:0] lane_res_t;

    // Exact floor(x / 255) for any x up to 255 * 255.
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] t;
        t = {1'b0, x} + {{PROD_W{1'b0}}, 1'b1} + {{(CHAN_W + 1){1'b0}}, x[PROD_W-1:CHAN_W]};
        return t[PROD_W-1:CHAN_W];
    endfunction

endpackage

// ----- src/argb_pixel_channel_alu.sv -----
// ARGB8888 per-channel pixel ALU. Each beat carries an operation code and two
// packed pixels; four channel lanes work side by side and one packed pixel
// leaves per input beat. The first stage registers the 8x8 channel products,
// the second forms the divide-by-255 and the selected result into the output
// register. A new beat is accepted every cycle while the output is not stalled,
// and a beat still enters while a finished pixel waits on the output, as long as
// the first stage is empty or can move on. Codes 6 and 7 give a zero pixel.
// Depends on apca_pkg, apca_lane and apca_merge.
module argb_pixel_channel_alu
    import apca_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // Fields from bit 0: colour_first [31:0], colour_second [63:32].
    input  logic [2*PIX_W-1:0]   s_axis_tdata,
    // Fields from bit 0: func [2:0].
    input  logic [FUNC_W-1:0]    s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // Fields from bit 0: colour_result [31:0].
    output logic [PIX_W-1:0]     m_axis_tdata
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       s2_ready;
    lane_ctl_t  ctl;
    lane_res_t  lane_res;
    logic [PIX_W-1:0] pix_first;
    logic [PIX_W-1:0] pix_second;

    assign pix_first  = s_axis_tdata[PIX_W-1:0];
    assign pix_second = s_axis_tdata[2*PIX_W-1:PIX_W];

    assign s_axis_tready = !s1_valid_reg || s2_ready;
    assign ctl.load_s1   = s_axis_tvalid && s_axis_tready;
    assign s1_valid_next = s_axis_tready ? s_axis_tvalid : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_lane
        apca_lane u_lane
        (
            .clk    (clk),
            .ctl    (ctl),
            .func   (s_axis_tuser),
            .c1     (pix_first[k*CHAN_W +: CHAN_W]),
            .c2     (pix_second[k*CHAN_W +: CHAN_W]),
            .a1     (pix_first[ALPHA_LANE*CHAN_W +: CHAN_W]),
            .result (lane_res[k])
        );
    end

    apca_merge u_merge
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid_reg),
        .lane_res (lane_res),
        .m_ready  (m_axis_tready),
        .s2_ready (s2_ready),
        .m_valid  (m_axis_tvalid),
        .m_data   (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // With both stages full and the output stalled, no beat may enter.
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while pipeline is full and stalled");

    // An accepted beat always occupies the first stage on the next cycle.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> s1_valid_reg)
        else $error("accepted beat lost before first stage");

    // A first-stage beat that moves on shows up on the output next cycle.
    a_s1_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_ready) |=> m_axis_tvalid)
        else $error("first-stage beat did not reach output");
`endif

endmodule

// ----- src/apca_lane.sv -----
// One channel lane: registers the channel products in the first stage and
// forms the per-operation result combinationally from those registers.
// Depends on apca_pkg.
module apca_lane
    import apca_pkg::*;
(
    input  logic              clk,
    input  lane_ctl_t         ctl,
    input  logic [FUNC_W-1:0] func,
    input  logic [CHAN_W-1:0] c1,
    input  logic [CHAN_W-1:0] c2,
    input  logic [CHAN_W-1:0] a1,
    output logic [CHAN_W-1:0] result
);

    logic [FUNC_W-1:0] func_reg;
    logic [CHAN_W-1:0] c1_reg;
    logic [CHAN_W-1:0] c2_reg;
    logic [PROD_W-1:0] prod_a_reg;
    logic [PROD_W-1:0] prod_b_reg;

    logic [CHAN_W-1:0] mul_b;
    logic [PROD_W-1:0] prod_a_next;
    logic [PROD_W-1:0] prod_b_next;
    logic [PROD_W-1:0] weighted_sum;
    logic [CHAN_W:0]   chan_sum;

    // Modulate uses c1*c2; blend uses c1*a1 plus c2*(255-a1).
    always_comb
    begin
        mul_b       = (func == FUNC_BLEND) ? a1 : c2;
        prod_a_next = PROD_W'(c1) * PROD_W'(mul_b);
        prod_b_next = (func == FUNC_BLEND) ? PROD_W'(c2) * PROD_W'(CHAN_MAX - a1)
                                           : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_s1)
        begin
            func_reg   <= func;
            c1_reg     <= c1;
            c2_reg     <= c2;
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
    end

    // The weighted sum never exceeds 255*255, so it fits in the product width.
    assign weighted_sum = prod_a_reg + prod_b_reg;
    assign chan_sum     = {1'b0, c1_reg} + {1'b0, c2_reg};

    always_comb
    begin
        case (func_reg)
            FUNC_ADD:   result = chan_sum[CHAN_W] ? CHAN_MAX : chan_sum[CHAN_W-1:0];
            FUNC_SUB:   result = (c1_reg > c2_reg) ? (c1_reg - c2_reg) : '0;
            FUNC_MIN:   result = (c1_reg < c2_reg) ? c1_reg : c2_reg;
            FUNC_MAX:   result = (c1_reg > c2_reg) ? c1_reg : c2_reg;
            FUNC_MOD:   result = div255(weighted_sum);
            FUNC_BLEND: result = div255(weighted_sum);
            default:    result = '0;
        endcase
    end

endmodule

// ----- src/apca_merge.sv -----
// Merging stage: packs the four lane results into one pixel and holds it in
// the output register until the downstream side takes the beat.
// Depends on apca_pkg.
module apca_merge
    import apca_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s1_valid,
    input  lane_res_t        lane_res,
    input  logic             m_ready,
    output logic             s2_ready,
    output logic             m_valid,
    output logic [PIX_W-1:0] m_data
);

    logic             valid_reg;
    logic             valid_next;
    logic [PIX_W-1:0] data_reg;

    assign s2_ready   = !valid_reg || m_ready;
    assign valid_next = s2_ready ? s1_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid)
        begin
            data_reg <= lane_res;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Stream testbench for argb_pixel_channel_alu: a queue-fed driver, a monitor with its own
// per-channel pixel predictor, random idling and stalls on both sides.
// Depends on apca_pkg and the RTL of argb_pixel_channel_alu.
module tb;
    import apca_pkg::*;

    // The two codes that name no operation.
    localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PIX_W-1:0]  first;
        logic [PIX_W-1:0]  second;
    } pix_beat_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // Fields from bit 0: colour_first [31:0], colour_second [63:32].
    logic [2*PIX_W-1:0]  s_axis_tdata = '0;
    // Fields from bit 0: func [2:0].
    logic [FUNC_W-1:0]   s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // Fields from bit 0: colour_result [31:0].
    logic [PIX_W-1:0]    m_axis_tdata;

    pix_beat_t           beat_q[$];
    logic [PIX_W-1:0]    pixel_q[$];
    pix_beat_t           drv_beat;
    logic [PIX_W-1:0]    want_pixel;
    bit                  in_fire = 1'b0;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    bit                  stall_req = 1'b0;
    int                  stall_left = 0;
    int                  errors = 0;

    argb_pixel_channel_alu u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Expected packed pixel for one operation on two pixels, channel by channel.
    function automatic logic [PIX_W-1:0] predict_pixel(input logic [FUNC_W-1:0] func,
                                                       input logic [PIX_W-1:0] first,
                                                       input logic [PIX_W-1:0] second);
        logic [PIX_W-1:0] pix;
        int unsigned      x;
        int unsigned      y;
        int unsigned      a;
        int unsigned      r;
        pix = '0;
        a = 32'(first[PIX_W-1 -: CHAN_W]);
        for (int k = 0; k < NUM_LANES; k++)
        begin
            x = 32'(first[k*CHAN_W +: CHAN_W]);
            y = 32'(second[k*CHAN_W +: CHAN_W]);
            case (func)
                FUNC_ADD:   r = (x + y > 255) ? 255 : x + y;
                FUNC_SUB:   r = (x > y) ? x - y : 0;
                FUNC_MIN:   r = (x < y) ? x : y;
                FUNC_MAX:   r = (x > y) ? x : y;
                FUNC_MOD:   r = (x * y) / 255;
                FUNC_BLEND: r = (x * a + y * (255 - a)) / 255;
                default:    r = 0;
            endcase
            pix[k*CHAN_W +: CHAN_W] = r[CHAN_W-1:0];
        end
        return pix;
    endfunction

    // Channel values lean toward the ends of the range, where clamping happens.
    function automatic logic [CHAN_W-1:0] rand_chan();
        logic [CHAN_W-1:0] c;
        case ($urandom_range(7))
            0:       c = 8'h00;
            1:       c = 8'hff;
            2:       c = CHAN_W'($urandom_range(16));
            3:       c = CHAN_W'($urandom_range(255, 239));
            default: c = CHAN_W'($urandom);
        endcase
        return c;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] p;
        if ($urandom_range(1))
            p = $urandom;
        else
            p = {rand_chan(), rand_chan(), rand_chan(), rand_chan()};
        return p;
    endfunction

    function automatic pix_beat_t rand_beat();
        pix_beat_t b;
        int        r;
        r = $urandom_range(99);
        if (r < 92)
            b.func = FUNC_W'(r % 6);
        else
            b.func = (r % 2 == 0) ? FUNC_RSVD6 : FUNC_RSVD7;
        b.first = rand_pixel();
        case ($urandom_range(5))
            0:       b.second = b.first;
            1:       b.second = ~b.first;
            default: b.second = rand_pixel();
        endcase
        return b;
    endfunction

    // Sender: a new beat goes out only once the previous one has been taken.
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_fire))
        begin
            if (beat_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                drv_beat = beat_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {drv_beat.second, drv_beat.first};
                s_axis_tuser  <= drv_beat.func;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus an occasional long hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_req)
            begin
                stall_left = 300;
                stall_req  = 1'b0;
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Monitor: check each result beat, then record the prediction for each input beat.
    always @(posedge clk)
    begin
        in_fire = s_axis_tvalid && s_axis_tready;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pixel_q.size() == 0)
            begin
                $display("%0t: result with nothing pending, expected none, actual %08h",
                         $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want_pixel = pixel_q.pop_front();
                if (m_axis_tdata !== want_pixel)
                begin
                    $display("%0t: colour_result mismatch, expected %08h, actual %08h",
                             $time, want_pixel, m_axis_tdata);
                    errors++;
                end
            end
        end
        if (in_fire)
            pixel_q.push_back(predict_pixel(s_axis_tuser, s_axis_tdata[PIX_W-1:0],
                                            s_axis_tdata[2*PIX_W-1:PIX_W]));
    end

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (beat_q.size() > 0 || s_axis_tvalid || pixel_q.size() > 0);
    endtask

    task automatic add_beat(input logic [FUNC_W-1:0] func, input logic [PIX_W-1:0] first,
                            input logic [PIX_W-1:0] second);
        pix_beat_t b;
        b.func   = func;
        b.first  = first;
        b.second = second;
        beat_q.push_back(b);
    endtask

    task automatic run_phase(input int count, input int s_idle, input int r_idle,
                             input bit long_stall);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < count; i++)
            beat_q.push_back(rand_beat());
        if (long_stall)
        begin
            repeat (40) @(posedge clk);
            #1 stall_req = 1'b1;
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        #3 rst_n = 1'b1;
        send_idle_pct = 13;
        recv_idle_pct = 45;

        // Saturation, clamping, equal and opposite channels, blend weights at both ends,
        // and the two undefined codes.
        add_beat(FUNC_ADD,   32'hffffffff, 32'h01010101);
        add_beat(FUNC_ADD,   32'h00000000, 32'h00000000);
        add_beat(FUNC_ADD,   32'h80fe0110, 32'h80017fef);
        add_beat(FUNC_SUB,   32'h00000000, 32'hffffffff);
        add_beat(FUNC_SUB,   32'hffffffff, 32'h00000000);
        add_beat(FUNC_SUB,   32'h10207f80, 32'h11207e81);
        add_beat(FUNC_MIN,   32'h00ff00ff, 32'hff00ff00);
        add_beat(FUNC_MIN,   32'h12345678, 32'h12345678);
        add_beat(FUNC_MAX,   32'h00ff00ff, 32'hff00ff00);
        add_beat(FUNC_MAX,   32'h00000000, 32'hffffffff);
        add_beat(FUNC_MOD,   32'hffffffff, 32'hffffffff);
        add_beat(FUNC_MOD,   32'h00ff80fe, 32'hff0080fe);
        add_beat(FUNC_MOD,   32'h01020304, 32'hff7f4020);
        add_beat(FUNC_BLEND, 32'hffa05010, 32'h00112233);
        add_beat(FUNC_BLEND, 32'h00a05010, 32'hff112233);
        add_beat(FUNC_BLEND, 32'h80ff00ff, 32'hff00ff00);
        add_beat(FUNC_BLEND, 32'hffffffff, 32'hffffffff);
        add_beat(FUNC_BLEND, 32'h00000000, 32'h00000000);
        add_beat(FUNC_RSVD6, 32'hffffffff, 32'hffffffff);
        add_beat(FUNC_RSVD7, 32'hffffffff, 32'h01234567);
        add_beat(FUNC_RSVD6, 32'h00000000, 32'h00000000);
        wait_drained();

        run_phase(380, 13, 45, 1'b0);
        run_phase(380, 45, 13, 1'b0);
        run_phase(390, 0, 0, 1'b1);

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
